[rtl/core/hced_pkg.sv]
// Package for the chunked transfer-encoding detector.
// Holds the phase type, the beat structs and the key and word letter tables.
// No dependencies.
`default_nettype none

package hced_pkg;

    localparam int KEY_LEN  = 17;
    localparam int WORD_LEN = 7;
    localparam int KEY_POS_W  = 5;
    localparam int WORD_POS_W = 3;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    localparam logic [7:0] KEY_UP [KEY_LEN] = '{
        8'h54, 8'h52, 8'h41, 8'h4E, 8'h53, 8'h46, 8'h45, 8'h52, 8'h2D,
        8'h45, 8'h4E, 8'h43, 8'h4F, 8'h44, 8'h49, 8'h4E, 8'h47
    };
    localparam logic [7:0] KEY_LO [KEY_LEN] = '{
        8'h74, 8'h72, 8'h61, 8'h6E, 8'h73, 8'h66, 8'h65, 8'h72, 8'h2D,
        8'h65, 8'h6E, 8'h63, 8'h6F, 8'h64, 8'h69, 8'h6E, 8'h67
    };
    localparam logic [7:0] WORD_UP [WORD_LEN] = '{
        8'h43, 8'h48, 8'h55, 8'h4E, 8'h4B, 8'h45, 8'h44
    };
    localparam logic [7:0] WORD_LO [WORD_LEN] = '{
        8'h63, 8'h68, 8'h75, 8'h6E, 8'h6B, 8'h65, 8'h64
    };

    typedef enum logic [1:0] {
        PH_KEY    = 2'd0,
        PH_SKIP   = 2'd1,
        PH_VALUE  = 2'd2,
        PH_REJECT = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_end;
    } t_beat;

    typedef struct packed {
        logic valid;
        logic is_chunked;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/hced_core.sv]
// Line scanning automaton of the chunked transfer-encoding detector.
// Depends on hced_pkg for the phase type, the beat structs and the letter tables.
`default_nettype none

module hced_core import hced_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_en,
    input  wire t_beat   i_beat,
    output t_result      o_result
);

    t_phase                  r_phase, n_phase;
    logic [KEY_POS_W-1:0]    r_key_pos, n_key_pos;
    logic [WORD_POS_W-1:0]   r_match, n_match;
    logic                    r_found, n_found;

    logic [7:0] b;
    logic       key_hit;
    logic       word_hit;
    logic       is_c;
    logic       do_search;

    assign b        = i_beat.line_byte;
    assign key_hit  = (b == KEY_UP[r_key_pos]) || (b == KEY_LO[r_key_pos]);
    assign word_hit = (b == WORD_UP[r_match]) || (b == WORD_LO[r_match]);
    assign is_c     = (b == WORD_UP[0]) || (b == WORD_LO[0]);

    always_comb begin
        n_phase   = r_phase;
        n_key_pos = r_key_pos;
        n_match   = r_match;
        n_found   = r_found;
        do_search = 1'b0;

        case (r_phase)
            PH_KEY: begin
                if (r_key_pos >= KEY_POS_W'(KEY_LEN)) begin
                    n_phase = (b == CHAR_COLON) ? PH_SKIP : PH_REJECT;
                end else if (key_hit) begin
                    n_key_pos = r_key_pos + 1'b1;
                end else begin
                    n_phase = PH_REJECT;
                end
            end
            PH_SKIP: begin
                if (b != CHAR_SPACE && b != CHAR_TAB) begin
                    n_phase   = PH_VALUE;
                    do_search = 1'b1;
                end
            end
            PH_VALUE: begin
                do_search = 1'b1;
            end
            default: begin
            end
        endcase

        // Search step; "chunked" has no repeated letter, so a miss restarts
        // at one on a 'c' and at zero otherwise.
        if (do_search && !r_found) begin
            if (word_hit) begin
                if (r_match == WORD_POS_W'(WORD_LEN - 1)) begin
                    n_found = 1'b1;
                    n_match = '0;
                end else begin
                    n_match = r_match + 1'b1;
                end
            end else if (is_c) begin
                n_match = WORD_POS_W'(1);
            end else begin
                n_match = '0;
            end
        end

        o_result.valid      = i_en && i_beat.line_end;
        o_result.is_chunked = (n_phase == PH_VALUE) && n_found;

        // The line-ending beat returns the automaton to its reset state.
        if (i_beat.line_end) begin
            n_phase   = PH_KEY;
            n_key_pos = '0;
            n_match   = '0;
            n_found   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_KEY;
            r_key_pos <= '0;
            r_match   <= '0;
            r_found   <= 1'b0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_key_pos <= n_key_pos;
            r_match   <= n_match;
            r_found   <= n_found;
        end
    end

endmodule

`default_nettype wire

[rtl/core/hced_out_reg.sv]
// Result register of the chunked transfer-encoding detector.
// Holds one finished flag until the downstream side takes it; uses hced_pkg.
`default_nettype none

module hced_out_reg import hced_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_result i_result,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output logic         o_is_chunked
);

    logic r_valid;
    logic r_flag;

    assign o_free       = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_is_chunked = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_result.valid) begin
            r_flag <= i_result.is_chunked;
        end
    end

endmodule

`default_nettype wire

[rtl/core/http_chunked_encoding_detector.sv]
// Chunked transfer-encoding detector, top level.
// A line-ending beat passes the input register, then the result register, to the master side.
// One beat per cycle, bar a line end held by a full result register; one automaton step per beat.
// Reset (synchronous, active low) empties the input and result registers and puts
// the automaton back to key matching. Depends on hced_pkg, hced_core, hced_out_reg.
`default_nettype none

module http_chunked_encoding_detector import hced_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Slave side: one byte of an HTTP header line per beat.
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] line_byte
    input  wire logic       i_s_tlast,   // line_end
    // Master side: one beat per line, on the line's last byte.
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata    // [0] is_chunked, [7:1] zero
);

    // Input register. A beat moves into the automaton when it produces no
    // result, or when the result register can take one in this cycle.
    logic    r_in_valid;
    t_beat   r_in;
    logic    proc;
    logic    out_free;
    logic    out_flag;
    t_result result;

    assign proc       = r_in_valid && (!r_in.line_end || out_free);
    assign o_s_tready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.line_byte <= i_s_tdata;
            r_in.line_end  <= i_s_tlast;
        end
    end

    // Key match, colon check, blank skip and "chunked" search, one beat per cycle unless stalled.
    hced_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (proc),
        .i_beat   (r_in),
        .o_result (result)
    );

    // Result register; it frees in the same cycle the downstream side takes
    // its beat, so back-to-back lines flow without a bubble.
    hced_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_result     (result),
        .o_free       (out_free),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_is_chunked (out_flag)
    );

    assign o_m_tdata = {7'b0, out_flag};

endmodule

`default_nettype wire

[tb/tb_http_chunked_encoding_detector.sv]
// Self-checking testbench for http_chunked_encoding_detector: header lines go in one byte
// per beat, and the flag beat of each line is checked against a local line scanner.
// Depends on hced_pkg and the detector RTL.
`timescale 1ns / 100ps

module tb_http_chunked_encoding_detector;
    import hced_pkg::*;

    // Header key and value word, lower case, first character in the top byte.
    localparam logic [8*17-1:0] KEY_TEXT  = "transfer-encoding";
    localparam logic [8*7-1:0]  WORD_TEXT = "chunked";
    localparam int KEY_CHARS  = 17;
    localparam int WORD_CHARS = 7;
    // Random part length in bytes, and the number of cycles without any beat
    // on either side after which the run is declared hung.
    localparam int RANDOM_BEATS = 510;
    localparam int STALL_LIMIT  = 2000;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'd0;  // [7:0] line_byte
    logic       i_s_tlast  = 1'b0;  // line_end
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;          // [0] is_chunked, [7:1] zero

    http_chunked_encoding_detector uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Bytes still to be sent, the line under construction, and the flags that
    // the lines accepted so far should produce, oldest first.
    t_beat      line_beats[$];
    logic [7:0] line_buf[$];
    logic       flags_due[$];
    string      key_str = "transfer-encoding";

    // Local copy of the scanner state.
    t_phase     scan_phase = PH_KEY;
    logic [4:0] key_pos    = '0;
    logic [2:0] word_len   = '0;
    logic       word_seen  = 1'b0;

    int  err_count   = 0;
    int  idle_cycles = 0;
    bit  beat_held   = 1'b0;
    int  send_gap    = 0;
    int  send_calm   = 0;
    int  stall_left  = 0;
    int  rcv_calm    = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 88) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 15);
        else return $urandom_range(30, 80);
    endfunction

    // Advances the scanner by one accepted byte. On the line-ending byte the
    // expected flag is queued and the scanner goes back to key matching.
    task automatic scan_header_byte(input logic [7:0] b, input logic last);
        logic [7:0] lc;
        logic       searching;
        lc = (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
        searching = 1'b0;
        case (scan_phase)
            PH_KEY: begin
                // Once the whole key has matched, only a colon may follow.
                if (key_pos >= KEY_CHARS)
                    scan_phase = (b == CHAR_COLON) ? PH_SKIP : PH_REJECT;
                else if (lc == KEY_TEXT[8*(KEY_CHARS-1-key_pos) +: 8])
                    key_pos = key_pos + 1'b1;
                else
                    scan_phase = PH_REJECT;
            end
            PH_SKIP: begin
                // The first non-blank byte already belongs to the value.
                if (b != CHAR_SPACE && b != CHAR_TAB) begin
                    scan_phase = PH_VALUE;
                    searching = 1'b1;
                end
            end
            PH_VALUE: searching = 1'b1;
            default: ;
        endcase
        if (searching && !word_seen) begin
            // The word has no repeated letter, so a mismatch restarts the
            // partial match at one on a 'c' and at zero on anything else.
            if (lc == WORD_TEXT[8*(WORD_CHARS-1-word_len) +: 8]) begin
                if (word_len == WORD_CHARS-1) begin
                    word_seen = 1'b1;
                    word_len = '0;
                end else begin
                    word_len = word_len + 1'b1;
                end
            end else if (lc == "c") begin
                word_len = 3'd1;
            end else begin
                word_len = '0;
            end
        end
        if (last) begin
            flags_due.push_back(scan_phase == PH_VALUE && word_seen);
            scan_phase = PH_KEY;
            key_pos = '0;
            word_len = '0;
            word_seen = 1'b0;
        end
    endtask

    // Appends text to the line; with mixed set each letter gets a random case.
    task automatic add_text(input string s, input bit mixed);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mixed && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
                $urandom_range(0, 1))
                c = c ^ 8'h20;
            line_buf.push_back(c);
        end
    endtask

    // Moves the line into the send queue, marking its last byte.
    task automatic flush_line();
        t_beat bt;
        for (int i = 0; i < line_buf.size(); i++) begin
            bt.line_byte = line_buf[i];
            bt.line_end  = (i == line_buf.size() - 1);
            line_beats.push_back(bt);
        end
        line_buf.delete();
    endtask

    // A full key in random case, a colon, some blanks and a value made of
    // tokens that hit, nearly hit or miss the word. No tokens at all makes a
    // line that ends while blanks are still being skipped.
    task automatic add_header_line();
        add_text("transfer-encoding", 1'b1);
        line_buf.push_back(CHAR_COLON);
        repeat ($urandom_range(0, 3))
            line_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 7))
                0, 1: add_text("chunked", 1'b1);
                2: add_text("chun", 1'b1);
                3: add_text("gzip", 1'b1);
                4: add_text(", ", 1'b0);
                5: add_text("cchunke", 1'b1);
                6: line_buf.push_back(CHAR_TAB);
                default: line_buf.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // Stimulus: directed lines first, then random lines until enough bytes are queued.
    initial begin : stimulus
        int directed_beats;
        int pick;

        add_text("Transfer-Encoding: chunked", 1'b0);          flush_line();
        add_text("TRANSFER-ENCODING:CHUNKED", 1'b0);           flush_line();
        add_text("tRaNsFeR-eNcOdInG:\t \tgzip, ChUnKeD", 1'b0); flush_line();
        // Early colon, then a wrong byte right after the full key.
        add_text("transfer-encodin:chunked", 1'b0);            flush_line();
        add_text("transfer-encodingx: chunked", 1'b0);         flush_line();
        add_text("content-length: 12", 1'b0);                  flush_line();
        // Lines that end during key matching and during blank skipping.
        add_text("transfer-enc", 1'b0);                        flush_line();
        add_text("transfer-encoding:", 1'b0);                  flush_line();
        add_text("transfer-encoding: \t ", 1'b0);              flush_line();
        // The first value byte is also the last byte of the line.
        add_text("transfer-encoding:x", 1'b0);                 flush_line();
        add_text("transfer-encoding: cchunked", 1'b0);         flush_line();
        add_text("transfer-encoding: chunkchunked", 1'b0);     flush_line();
        add_text("transfer-encoding: chunke", 1'b0);           flush_line();
        add_text("transfer-encoding: chunked, gzip", 1'b0);    flush_line();
        // Extreme byte values as whole one-byte lines.
        line_buf.push_back(8'hFF);                             flush_line();
        line_buf.push_back(8'h00);                             flush_line();
        directed_beats = line_beats.size();

        while (line_beats.size() < directed_beats + RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                add_header_line();
            end else if (pick < 65) begin
                // Well-formed line with one byte of the key or colon spoiled.
                add_header_line();
                line_buf[$urandom_range(0, KEY_CHARS)] = 8'($urandom_range(0, 255));
            end else if (pick < 72) begin
                add_text(key_str.substr(0, $urandom_range(0, KEY_CHARS - 2)), 1'b1);
                if ($urandom_range(0, 1)) add_text(":chunked", 1'b1);
            end else if (pick < 87) begin
                repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                add_text("content-length: 42", 1'b1);
            end
            flush_line();
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every byte to go in and every flag to come out, then let
        // the clock run on so that any extra result beat would show.
        while (line_beats.size() > 0 || beat_held) @(posedge i_clk);
        while (flags_due.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Driver: presents queued bytes, feeds each accepted beat to the scanner,
    // and inserts random gaps between beats, with calm stretches of none.
    always @(posedge i_clk) begin : line_driver
        t_beat bt;
        bit    held_next;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            held_next = beat_held;
            if (i_s_tvalid && o_s_tready) begin
                scan_header_byte(i_s_tdata, i_s_tlast);
                held_next = 1'b0;
                if (send_calm > 0) begin
                    send_calm--;
                    send_gap = 0;
                end else begin
                    send_gap = pick_idle();
                    if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 100);
                end
            end
            if (!held_next && line_beats.size() > 0) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else begin
                    bt = line_beats.pop_front();
                    i_s_tdata <= bt.line_byte;
                    i_s_tlast <= bt.line_end;
                    held_next = 1'b1;
                end
            end
            beat_held = held_next;
            i_s_tvalid <= held_next;
        end
    end

    // Monitor: stalls the master side at random and checks each flag beat
    // against the oldest expected flag.
    always @(posedge i_clk) begin : flag_monitor
        logic want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (flags_due.size() == 0) begin
                    $error("unexpected result beat: is_chunked=%0b", o_m_tdata[0]);
                    err_count++;
                end else begin
                    want = flags_due.pop_front();
                    if (o_m_tdata[0] !== want) begin
                        $error("is_chunked: expected %0b, actual %0b", want, o_m_tdata[0]);
                        err_count++;
                    end
                    if (o_m_tdata[7:1] !== 7'd0) begin
                        $error("tdata padding: expected 0, actual %0h", o_m_tdata[7:1]);
                        err_count++;
                    end
                end
            end
        end
        if (stall_left == 0) begin
            if (rcv_calm > 0) begin
                rcv_calm--;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_idle();
                if ($urandom_range(0, 49) == 0) rcv_calm = $urandom_range(20, 100);
            end
        end
        i_m_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
    end

    // Watchdog: a long run of cycles without a beat on either side means a hang.
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
